// File: hw/rtl/c2br_pkg.sv
`timescale 1ns / 1ps

package c2br_pkg;

    // item opcodes
    typedef enum logic [1:0] {
        OP_WR_ACT  = 2'd0,
        OP_WR_WGT  = 2'd1,
        OP_WR_BIAS = 2'd2,
        OP_COMPUTE = 2'd3
    } t_action;

    // fixed field widths
    localparam int unsigned DATA_W = 16;
    localparam int unsigned BIAS_W = 32;
    localparam int unsigned PROD_W = 32;
    localparam int unsigned ACC_W  = 48;
    localparam int unsigned OUT_W  = 15;
    localparam int unsigned FRAC_SHIFT = 8;

    // control that travels with each tap through the mac pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

// File: hw/rtl/c2br_mac.sv
`timescale 1ns / 1ps

module c2br_mac
    import c2br_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mac_ctl                   i_ctl,
    input  logic signed [DATA_W-1:0]   i_act,
    input  logic signed [DATA_W-1:0]   i_wgt,
    input  logic signed [BIAS_W-1:0]   i_bias,
    output logic                       o_res_valid,
    output logic        [OUT_W-1:0]    o_res_value
);

    t_mac_ctl                  r_p_ctl;
    logic signed [PROD_W-1:0]  r_prod;
    t_mac_ctl                  r_a_ctl;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   n_acc;
    logic                      r_res_valid;
    logic        [OUT_W-1:0]   r_res_value;
    logic        [OUT_W-1:0]   n_res_value;
    logic [ACC_W-FRAC_SHIFT-2:0] sh_acc;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
        end else begin
            r_p_ctl <= i_ctl;
        end
        r_prod <= PROD_W'(i_act) * PROD_W'(i_wgt);
    end

    // accumulate stage, bias loaded with the first tap, wraps at 48 bits
    always_comb begin
        if (r_p_ctl.first) begin
            n_acc = ACC_W'(i_bias) + ACC_W'(r_prod);
        end else begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else begin
            r_a_ctl <= r_p_ctl;
        end
        if (r_p_ctl.valid) begin
            r_acc <= n_acc;
        end
    end

    // relu, drop fraction bits, saturate to 15 bits
    assign sh_acc = r_acc[ACC_W-2:FRAC_SHIFT];

    always_comb begin
        if (r_acc[ACC_W-1]) begin
            n_res_value = '0;
        end else if (|sh_acc[$bits(sh_acc)-1:OUT_W]) begin
            n_res_value = '1;
        end else begin
            n_res_value = sh_acc[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= r_a_ctl.valid & r_a_ctl.last;
        end
        r_res_value <= n_res_value;
    end

    assign o_res_valid = r_res_valid;
    assign o_res_value = r_res_value;

endmodule

// File: hw/rtl/conv2d_bias_relu.sv
`timescale 1ns / 1ps

// conv2d_bias_relu: one tile of a convolution layer with bias and relu.
// Input channel: a beat is taken when i_start is high and o_busy is low.
// Opcodes on i_action write an activation, a weight or a bias (no result)
// or request one output element. Writes outside the configured sizes are
// dropped.
// Compute: a valid output coordinate walks KSIZE*KSIZE*IN_CH taps through
// one shared multiply-accumulate, one tap per cycle, fed by the activation
// and weight memories (one read port each). o_busy stays high from the
// accept until the result beat, so no new beat is taken while a compute
// runs; that tap walk sets the rate.
// An out-of-range coordinate returns out_value 0 with o_coord_error set,
// registered through r_err_pend, without raising o_busy.
// Result channel: o_valid marks each result beat for one cycle; the
// receiver cannot stall, so results are never held.
// Reset clears the sequencer and pipeline valid bits only; memory contents
// are undefined until written.
module conv2d_bias_relu
    import c2br_pkg::*;
#(
    parameter int unsigned IMG_W  = 16,
    parameter int unsigned IMG_H  = 16,
    parameter int unsigned IN_CH  = 16,
    parameter int unsigned OUT_CH = 16,
    parameter int unsigned KSIZE  = 3
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [1:0]            i_action,
    input  logic [3:0]            i_col,
    input  logic [3:0]            i_row,
    input  logic [3:0]            i_in_chan,
    input  logic [3:0]            i_out_chan,
    input  logic [1:0]            i_tap_col,
    input  logic [1:0]            i_tap_row,
    input  logic signed [31:0]    i_value,
    output logic                  o_valid,
    output logic [OUT_W-1:0]      o_out_value,
    output logic                  o_coord_error
);

    localparam int unsigned ACT_DEPTH = IMG_W * IMG_H * IN_CH;
    localparam int unsigned WGT_DEPTH = OUT_CH * IN_CH * KSIZE * KSIZE;
    localparam int unsigned AAW = $clog2(ACT_DEPTH);
    localparam int unsigned WAW = $clog2(WGT_DEPTH);
    localparam int unsigned BAW = (OUT_CH > 1) ? $clog2(OUT_CH) : 1;
    localparam int unsigned CW  = (IN_CH > 1) ? $clog2(IN_CH) : 1;
    localparam int unsigned KW  = (KSIZE > 1) ? $clog2(KSIZE) : 1;
    localparam int unsigned STEP_ROW = IMG_W - (KSIZE - 1);
    localparam int unsigned STEP_CH  = IMG_W * IMG_H - (KSIZE - 1) * IMG_W - (KSIZE - 1);

    // saturate a 32-bit write value to signed q8.8
    function automatic logic [DATA_W-1:0] sat_q88(input logic signed [31:0] v);
        logic [DATA_W-1:0] res;
        if (v > 32'sd32767) begin
            res = 16'h7fff;
        end else if (v < -32'sd32768) begin
            res = 16'h8000;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    t_action                 action;
    logic                    accept;
    logic                    act_ok;
    logic                    wgt_ok;
    logic                    bias_ok;
    logic                    coord_bad;
    logic                    run_start;
    logic                    err_start;
    logic [AAW-1:0]          act_wr_addr;
    logic [WAW-1:0]          wgt_wr_addr;

    logic [DATA_W-1:0]       act_mem [ACT_DEPTH];
    logic [DATA_W-1:0]       wgt_mem [WGT_DEPTH];
    logic [BIAS_W-1:0]       bias_mem [OUT_CH];

    logic                    r_busy;
    logic                    r_run;
    logic [CW-1:0]           r_c;
    logic [KW-1:0]           r_r;
    logic [KW-1:0]           r_k;
    logic [AAW-1:0]          r_act_addr;
    logic [WAW-1:0]          r_wgt_addr;
    logic                    r_first;
    logic [CW-1:0]           n_c;
    logic [KW-1:0]           n_r;
    logic [KW-1:0]           n_k;
    logic [AAW-1:0]          n_act_addr;
    logic                    k_last;
    logic                    r_last_row;
    logic                    tap_last;

    t_mac_ctl                r_rd_ctl;
    logic [DATA_W-1:0]       r_act_q;
    logic [DATA_W-1:0]       r_wgt_q;
    logic [BIAS_W-1:0]       r_bias_q;
    logic                    mac_valid;
    logic [OUT_W-1:0]        mac_value;
    logic                    r_err_pend;

    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_value;
    logic                    r_out_err;

    // decode the input beat
    assign action = t_action'(i_action);
    assign accept = i_start & ~r_busy;

    assign act_ok  = (int'(i_col) < IMG_W) && (int'(i_row) < IMG_H) && (int'(i_in_chan) < IN_CH);
    assign wgt_ok  = (int'(i_out_chan) < OUT_CH) && (int'(i_in_chan) < IN_CH)
                  && (int'(i_tap_col) < KSIZE) && (int'(i_tap_row) < KSIZE);
    assign bias_ok = int'(i_out_chan) < OUT_CH;
    assign coord_bad = (int'(i_col) + KSIZE > IMG_W) || (int'(i_row) + KSIZE > IMG_H)
                    || (int'(i_out_chan) >= OUT_CH);

    assign run_start = accept && (action == OP_COMPUTE) && !coord_bad;
    assign err_start = accept && (action == OP_COMPUTE) && coord_bad;

    assign act_wr_addr = AAW'((int'(i_in_chan) * IMG_H + int'(i_row)) * IMG_W + int'(i_col));
    assign wgt_wr_addr = WAW'(((int'(i_out_chan) * IN_CH + int'(i_in_chan)) * KSIZE
                         + int'(i_tap_row)) * KSIZE + int'(i_tap_col));

    // stores: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (accept && (action == OP_WR_ACT) && act_ok) begin
            act_mem[act_wr_addr] <= sat_q88(i_value);
        end
        r_act_q <= act_mem[r_act_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && (action == OP_WR_WGT) && wgt_ok) begin
            wgt_mem[wgt_wr_addr] <= sat_q88(i_value);
        end
        r_wgt_q <= wgt_mem[r_wgt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && (action == OP_WR_BIAS) && bias_ok) begin
            bias_mem[BAW'(int'(i_out_chan))] <= i_value;
        end
        if (run_start) begin
            r_bias_q <= bias_mem[BAW'(int'(i_out_chan))];
        end
    end

    // tap walk: kernel column, kernel row, input channel
    assign k_last   = (r_k == KW'(KSIZE - 1));
    assign tap_last = k_last && r_last_row && (r_c == CW'(IN_CH - 1));

    always_comb begin
        n_k = r_k + 1'b1;
        n_r = r_r;
        n_c = r_c;
        n_act_addr = r_act_addr + 1'b1;
        if (k_last) begin
            n_k = '0;
            n_r = r_r + 1'b1;
            n_act_addr = r_act_addr + AAW'(STEP_ROW);
            if (r_last_row) begin
                n_r = '0;
                n_c = r_c + 1'b1;
                n_act_addr = r_act_addr + AAW'(STEP_CH);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_run  <= 1'b0;
        end else begin
            if (run_start) begin
                r_busy <= 1'b1;
                r_run  <= 1'b1;
            end else begin
                if (mac_valid) begin
                    r_busy <= 1'b0;
                end
                if (r_run && tap_last) begin
                    r_run <= 1'b0;
                end
            end
        end
        if (run_start) begin
            r_c        <= '0;
            r_r        <= '0;
            r_k        <= '0;
            r_last_row <= (KSIZE == 1);
            r_first    <= 1'b1;
            r_act_addr <= AAW'(int'(i_row) * IMG_W + int'(i_col));
            r_wgt_addr <= WAW'(int'(i_out_chan) * IN_CH * KSIZE * KSIZE);
        end else if (r_run) begin
            r_c        <= n_c;
            r_r        <= n_r;
            r_k        <= n_k;
            r_last_row <= (n_r == KW'(KSIZE - 1));
            r_first    <= 1'b0;
            r_act_addr <= n_act_addr;
            r_wgt_addr <= r_wgt_addr + 1'b1;
        end
    end

    // control beside the registered memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ctl <= '0;
        end else begin
            r_rd_ctl.valid <= r_run;
            r_rd_ctl.first <= r_run & r_first;
            r_rd_ctl.last  <= r_run & tap_last;
        end
    end

    c2br_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_rd_ctl),
        .i_act       (r_act_q),
        .i_wgt       (r_wgt_q),
        .i_bias      (r_bias_q),
        .o_res_valid (mac_valid),
        .o_res_value (mac_value)
    );

    // result beat register: mac result or coordinate error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_err_pend  <= err_start;
            r_out_valid <= mac_valid | r_err_pend;
        end
        r_out_err   <= r_err_pend;
        r_out_value <= r_err_pend ? '0 : mac_value;
    end

    assign o_busy        = r_busy;
    assign o_valid       = r_out_valid;
    assign o_out_value   = r_out_value;
    assign o_coord_error = r_out_err;

`ifndef SYNTHESIS
    // the tap walk only runs inside a busy window
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> r_busy)
        else $error("tap walk active while not busy");

    // a finished accumulation ends a busy window
    a_mac_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_valid |-> r_busy && !r_run && !r_err_pend)
        else $error("mac result outside its busy window");

    // a valid compute starts the walk on the next cycle
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run_start |=> r_run && r_first)
        else $error("compute accepted but walk did not start");

    // an error result carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_coord_error && o_valid |-> o_out_value == '0)
        else $error("coordinate error with nonzero value");

    // bad coordinates answer with an error beat, registered through r_err_pend, without a busy window
    a_err_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        err_start |=> !r_busy ##1 (o_valid && o_coord_error))
        else $error("coordinate error beat missing");
`endif

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import c2br_pkg::*;

    localparam int IMG_W  = 16;
    localparam int IMG_H  = 16;
    localparam int IN_CH  = 16;
    localparam int OUT_CH = 16;
    localparam int K      = 3;
    localparam int CYCLE_LIMIT = 1000000;

    // one output element as the block should return it
    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             err;
    } t_conv_result;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_start    = 1'b0;
    logic [1:0]         i_action   = '0;
    logic [3:0]         i_col      = '0;
    logic [3:0]         i_row      = '0;
    logic [3:0]         i_in_chan  = '0;
    logic [3:0]         i_out_chan = '0;
    logic [1:0]         i_tap_col  = '0;
    logic [1:0]         i_tap_row  = '0;
    logic signed [31:0] i_value    = '0;
    logic               o_busy;
    logic               o_valid;
    logic [OUT_W-1:0]   o_out_value;
    logic               o_coord_error;

    // shadow copies of the three stores
    logic [15:0] act_mem  [IMG_W*IMG_H*IN_CH];
    logic [15:0] wgt_mem  [OUT_CH*IN_CH*K*K];
    logic [31:0] bias_mem [OUT_CH];

    t_conv_result pending_results[$];

    int  errors        = 0;
    int  beats_sent    = 0;
    int  results_seen  = 0;
    int  coord_errs    = 0;
    int  cycle_count   = 0;
    bit  idle_en       = 1'b1;

    conv2d_bias_relu dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_action      (i_action),
        .i_col         (i_col),
        .i_row         (i_row),
        .i_in_chan     (i_in_chan),
        .i_out_chan    (i_out_chan),
        .i_tap_col     (i_tap_col),
        .i_tap_row     (i_tap_row),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_out_value   (o_out_value),
        .o_coord_error (o_coord_error)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // q8.8 load saturation
    function automatic logic [15:0] sat_word(input logic signed [31:0] v);
        if (v > 32'sd32767)
            return 16'h7FFF;
        else if (v < -32'sd32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic int wgt_index(input logic [3:0] oc, ic, input logic [1:0] tr, tc);
        return ((int'(oc) * IN_CH + int'(ic)) * K + int'(tr)) * K + int'(tc);
    endfunction

    // bias + sum of taps in a 48-bit accumulator, relu, >> 8, clamp
    function automatic t_conv_result conv_predict(input logic [3:0] col, row, oc);
        t_conv_result       res;
        logic signed [47:0] acc;
        logic signed [31:0] prod;
        logic signed [15:0] w;
        logic signed [15:0] a;
        res.value = '0;
        res.err   = 1'b0;
        if (col > IMG_W - K || row > IMG_H - K) begin
            res.err = 1'b1;
            return res;
        end
        acc = {{16{bias_mem[oc][31]}}, bias_mem[oc]};
        for (int c = 0; c < IN_CH; c++)
            for (int r = 0; r < K; r++)
                for (int k = 0; k < K; k++) begin
                    w = wgt_mem[wgt_index(oc, c[3:0], r[1:0], k[1:0])];
                    a = act_mem[(c * IMG_H + int'(row) + r) * IMG_W + int'(col) + k];
                    prod = 32'(w) * 32'(a);
                    acc = acc + {{16{prod[31]}}, prod};
                end
        if (acc[47])
            res.value = '0;
        else if (acc[47:8] > 40'd32767)
            res.value = 15'h7FFF;
        else
            res.value = acc[22:8];
        return res;
    endfunction

    // drive one beat, wait for the accept, then update the shadow state
    task automatic send_beat(input t_action act, input logic [3:0] col, row, ic, oc,
                             input logic [1:0] tc, tr, input logic signed [31:0] val);
        i_start    <= 1'b1;
        i_action   <= act;
        i_col      <= col;
        i_row      <= row;
        i_in_chan  <= ic;
        i_out_chan <= oc;
        i_tap_col  <= tc;
        i_tap_row  <= tr;
        i_value    <= val;
        do @(posedge i_clk); while (o_busy);
        beats_sent++;
        case (act)
            OP_WR_ACT:  act_mem[(int'(ic) * IMG_H + int'(row)) * IMG_W + int'(col)] = sat_word(val);
            OP_WR_WGT:  if (tc < K && tr < K) wgt_mem[wgt_index(oc, ic, tr, tc)] = sat_word(val);
            OP_WR_BIAS: bias_mem[oc] = val;
            OP_COMPUTE: pending_results.push_back(conv_predict(col, row, oc));
        endcase
    endtask

    task automatic wr_act(input logic [3:0] col, row, ic, input logic signed [31:0] val);
        send_beat(OP_WR_ACT, col, row, ic, 4'($urandom()), 2'($urandom()), 2'($urandom()),
                  val);
    endtask

    task automatic wr_wgt(input logic [3:0] oc, ic, input logic [1:0] tr, tc,
                          input logic signed [31:0] val);
        send_beat(OP_WR_WGT, 4'($urandom()), 4'($urandom()), ic, oc, tc, tr, val);
    endtask

    task automatic wr_bias(input logic [3:0] oc, input logic signed [31:0] val);
        send_beat(OP_WR_BIAS, 4'($urandom()), 4'($urandom()), 4'($urandom()), oc,
                  2'($urandom()), 2'($urandom()), val);
    endtask

    task automatic compute(input logic [3:0] col, row, oc);
        send_beat(OP_COMPUTE, col, row, 4'($urandom()), oc, 2'($urandom()), 2'($urandom()),
                  $urandom());
    endtask

    // occasional random sender gap, sometimes placed right after the block frees up
    task automatic maybe_idle();
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            if ($urandom_range(0, 1) == 0) begin
                do @(posedge i_clk); while (o_busy);
            end
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // hold off until every outstanding result is back
    task automatic wait_all_results();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // activation / weight data: mostly small, some full range, some saturating
    function automatic logic signed [31:0] rand_word();
        logic [15:0] h;
        int          kind;
        kind = $urandom_range(0, 9);
        h    = 16'($urandom());
        if (kind < 6)
            return 32'($urandom_range(0, 2047)) - 32'd1024;
        else if (kind < 8)
            return {{16{h[15]}}, h};
        else if (kind == 8)
            return $urandom();
        case ($urandom_range(0, 3))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd32767;
            default: return -32'sd32768;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_bias();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 6)
            return 32'($urandom_range(0, 2 << 20)) - 32'd2097152;
        else if (kind < 9)
            return $urandom();
        return ($urandom_range(0, 1) == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endfunction

    function automatic logic [3:0] rand_out_coord();
        if ($urandom_range(0, 7) == 0)
            return 4'($urandom_range(IMG_W - K + 1, IMG_W - 1));
        return 4'($urandom_range(0, IMG_W - K));
    endfunction

    function automatic logic [1:0] rand_tap();
        if ($urandom_range(0, 15) == 0)
            return 2'd3;
        return 2'($urandom_range(0, K - 1));
    endfunction

    task automatic random_beat();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            compute(rand_out_coord(), rand_out_coord(), 4'($urandom()));
        else if (pick < 65)
            wr_act(4'($urandom()), 4'($urandom()), 4'($urandom()), rand_word());
        else if (pick < 90)
            wr_wgt(4'($urandom()), 4'($urandom()), rand_tap(), rand_tap(), rand_word());
        else
            wr_bias(4'($urandom()), rand_bias());
    endtask

    // fill every store entry so any compute reads written data
    task automatic test_preload();
        for (int ic = 0; ic < IN_CH; ic++)
            for (int r = 0; r < IMG_H; r++)
                for (int c = 0; c < IMG_W; c++) begin
                    maybe_idle();
                    wr_act(c[3:0], r[3:0], ic[3:0], 32'($urandom_range(0, 1023)) - 32'd512);
                end
        for (int oc = 0; oc < OUT_CH; oc++)
            for (int ic = 0; ic < IN_CH; ic++)
                for (int tr = 0; tr < K; tr++)
                    for (int tc = 0; tc < K; tc++) begin
                        maybe_idle();
                        wr_wgt(oc[3:0], ic[3:0], tr[1:0], tc[1:0],
                               32'($urandom_range(0, 1023)) - 32'd512);
                    end
        for (int oc = 0; oc < OUT_CH; oc++)
            wr_bias(oc[3:0], 32'($urandom_range(0, 1 << 20)) - 32'd524288);
    endtask

    // load saturation at both ends of the q8.8 range
    task automatic test_write_saturation();
        wr_act(4'd0, 4'd0, 4'd0, 32'sh7FFF_FFFF);
        wr_act(4'd1, 4'd0, 4'd0, 32'sh8000_0000);
        wr_act(4'd2, 4'd0, 4'd0, 32'sd32768);
        wr_act(4'd0, 4'd1, 4'd0, -32'sd32769);
        wr_wgt(4'd0, 4'd0, 2'd0, 2'd0, 32'sh7FFF_FFFF);
        wr_wgt(4'd0, 4'd0, 2'd0, 2'd1, 32'sh8000_0000);
        compute(4'd0, 4'd0, 4'd0);
    endtask

    // weight writes with a tap index past the kernel are dropped
    task automatic test_ignored_writes();
        wr_wgt(4'd5, 4'd3, 2'd3, 2'd0, 32'sd30000);
        wr_wgt(4'd5, 4'd3, 2'd0, 2'd3, 32'sd30000);
        wr_wgt(4'd5, 4'd3, 2'd3, 2'd3, -32'sd30000);
        compute(4'd0, 4'd0, 4'd5);
    endtask

    // extreme biases: clamp high and relu to zero
    task automatic test_bias_relu();
        wr_bias(4'd1, 32'sh7FFF_FFFF);
        compute(4'd5, 4'd5, 4'd1);
        wr_bias(4'd2, 32'sh8000_0000);
        compute(4'd5, 4'd5, 4'd2);
        wr_bias(4'd1, 32'sd4096);
        wr_bias(4'd2, -32'sd4096);
    endtask

    // last valid coordinates and out-of-range ones back to back
    task automatic test_coord_edges();
        compute(4'd13, 4'd13, 4'd15);
        compute(4'd14, 4'd0, 4'd0);
        compute(4'd0, 4'd14, 4'd0);
        compute(4'd15, 4'd15, 4'd15);
        wait_all_results();
        compute(4'd13, 4'd0, 4'd3);
        compute(4'd0, 4'd13, 4'd4);
    endtask

    task automatic test_random(input int count);
        repeat (count) begin
            maybe_idle();
            random_beat();
        end
    endtask

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: out_value %0d coord_error %0b",
                       o_out_value, o_coord_error);
                errors++;
            end else begin
                t_conv_result exp_res;
                exp_res = pending_results.pop_front();
                results_seen++;
                if (exp_res.err)
                    coord_errs++;
                if (o_out_value !== exp_res.value) begin
                    $error("out_value: expected %0d, got %0d", exp_res.value, o_out_value);
                    errors++;
                end
                if (o_coord_error !== exp_res.err) begin
                    $error("coord_error: expected %0b, got %0b", exp_res.err, o_coord_error);
                    errors++;
                end
            end
        end
    end

    initial begin : run_tests
        int guard;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_preload();
        test_write_saturation();
        test_ignored_writes();
        test_bias_relu();
        test_coord_edges();
        test_random(400);
        wait_all_results();
        idle_en = 1'b0;
        test_random(100);

        // let the last results drain, then watch for strays
        i_start <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (200) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end

        $display("tb: %0d beats sent (full store preload, directed edges, random mix)",
                 beats_sent);
        $display("tb: %0d results checked, %0d of them out-of-range coordinates",
                 results_seen, coord_errs);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
